>>> src/xacs_pkg.sv
// ----------------------------------------------------------------------------
// xacs_pkg: shared types and helpers for the attachment constraint step
// Status codes, request structs for the arithmetic units, and saturating
// helpers used by the sequencer.
// ----------------------------------------------------------------------------
package xacs_pkg;

  localparam int unsigned CompW  = 48;
  localparam int unsigned PosW   = 32;
  localparam int unsigned WideW  = 64;
  localparam int unsigned DistW  = 33;
  localparam int unsigned SumW   = 66;

  localparam logic [1:0] STATUS_UPDATED   = 2'd0;
  localparam logic [1:0] STATUS_NEAR_DIST = 2'd1;
  localparam logic [1:0] STATUS_NEAR_DEN  = 2'd2;

  localparam logic [1:0] REG_COMPLIANCE  = 2'd0;
  localparam logic [1:0] REG_REST_LENGTH = 2'd1;
  localparam logic [1:0] REG_TIME_STEP   = 2'd2;

  localparam logic [31:0] TIME_STEP_RESET = 32'd71582788;
  localparam logic [63:0] MOVE_LIMIT      = 64'h0000_0002_0000_0000;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] den;
  } div_req_t;

  // Signed add that clips at the 64-bit limits.
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] sum;
    sum = a + b;
    if (!a[63] && !b[63] && sum[63]) begin
      sat_add64 = {1'b0, {63{1'b1}}};
    end else if (a[63] && b[63] && !sum[63]) begin
      sat_add64 = {1'b1, {63{1'b0}}};
    end else begin
      sat_add64 = sum;
    end
  endfunction

  // Magnitude clipped to the largest positive value, then signed.
  function automatic logic signed [63:0] signed_from(input logic [63:0] m,
                                                     input logic neg);
    logic [63:0] mm;
    mm = m[63] ? {1'b0, {63{1'b1}}} : m;
    signed_from = neg ? -$signed(mm) : $signed(mm);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    mag64 = x[63] ? 64'(-x) : 64'(x);
  endfunction

  // Upper product bits shifted down by 32, saturating when they do not fit.
  function automatic logic [63:0] shift32_sat(input logic [127:0] p);
    shift32_sat = (p[127:96] != 32'd0) ? {64{1'b1}} : p[95:32];
  endfunction

endpackage

>>> src/xacs_if.sv
// ----------------------------------------------------------------------------
// xacs_if: ready/valid channels for items and results
// An item beat and a result beat, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface xacs_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [31:0] inv_mass;
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  logic signed [31:0] anchor_z;
  logic               clear_multiplier;

  modport source(output valid, pos_x, pos_y, pos_z, inv_mass, anchor_x, anchor_y,
                 anchor_z, clear_multiplier, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, inv_mass, anchor_x, anchor_y,
               anchor_z, clear_multiplier, output ready);
endinterface

interface xacs_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;
  logic signed [63:0] multiplier;
  logic        [1:0]  status;

  modport source(output valid, new_x, new_y, new_z, multiplier, status, input ready);
  modport sink(input valid, new_x, new_y, new_z, multiplier, status, output ready);
endinterface

>>> src/xacs_mul.sv
// ----------------------------------------------------------------------------
// xacs_mul: 64x64 multiplier over one 32x32 partial product per cycle
// Four partial products are formed and accumulated into a 128-bit result.
// ----------------------------------------------------------------------------
module xacs_mul
  import xacs_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  mul_req_t       req,
  output logic           done,
  output logic [127:0]   prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   cnt;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_valid;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [127:0] pp_shifted;

  always_comb begin
    case (cnt)
      3'd0: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
      3'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      3'd2: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
      default: begin
        op_a = a_r[63:32];
        op_b = b_r[63:32];
      end
    endcase
  end

  always_comb begin
    case (pp_sh)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      pp_valid <= 1'b0;
      cnt      <= 3'd0;
    end else begin
      done <= !req.start && busy && (cnt == 3'd4);
      if (req.start) begin
        a_r      <= req.a;
        b_r      <= req.b;
        cnt      <= 3'd0;
        busy     <= 1'b1;
        pp_valid <= 1'b0;
        prod     <= 128'd0;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          pp       <= 64'(op_a) * 64'(op_b);
          pp_sh    <= (cnt == 3'd0) ? 2'd0 : ((cnt == 3'd3) ? 2'd2 : 2'd1);
          pp_valid <= 1'b1;
        end
        if (pp_valid) begin
          prod <= prod + pp_shifted;
        end
        if (cnt == 3'd4) begin
          busy     <= 1'b0;
          pp_valid <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

>>> src/xacs_div.sv
// ----------------------------------------------------------------------------
// xacs_div: 128-by-64 restoring divider, one quotient bit per cycle
// A zero divisor or a quotient wider than 64 bits gives all ones at once.
// ----------------------------------------------------------------------------
module xacs_div
  import xacs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quot
);

  logic [63:0] rem;
  logic [63:0] lo_r;
  logic [63:0] den_r;
  logic [5:0]  cnt;
  logic        busy;
  logic [63:0] rem_sh;
  logic        take;

  assign rem_sh = {rem[62:0], lo_r[63]};
  assign take   = rem[63] || (rem_sh >= den_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= (req.start && (req.den == 64'd0 || req.hi >= req.den)) ||
              (!req.start && busy && (cnt == 6'd63));
      if (req.start) begin
        rem   <= req.hi;
        lo_r  <= req.lo;
        den_r <= req.den;
        cnt   <= 6'd0;
        if (req.den == 64'd0 || req.hi >= req.den) begin
          quot <= {64{1'b1}};
        end else begin
          quot <= 64'd0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        lo_r <= {lo_r[62:0], 1'b0};
        quot <= {quot[62:0], take};
        rem  <= take ? (rem_sh - den_r) : rem_sh;
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/xacs_sqrt.sv
// ----------------------------------------------------------------------------
// xacs_sqrt: digit-by-digit integer square root
// Takes two radicand bits per cycle and returns the floor of the root.
// ----------------------------------------------------------------------------
module xacs_sqrt
  import xacs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SumW-1:0]  radicand,
  output logic             done,
  output logic [DistW-1:0] root
);

  localparam int unsigned RemW = DistW + 2;

  logic [SumW-1:0]  rad_r;
  logic [RemW-1:0]  rem;
  logic [5:0]       cnt;
  logic             busy;
  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             take;
  logic [RemW+1:0]  diff;

  assign rem_sh = {rem, rad_r[SumW-1 -: 2]};
  assign trial  = (RemW+2)'({root, 2'b01});
  assign take   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= !start && busy && (cnt == 6'(SumW/2 - 1));
      if (start) begin
        rad_r <= radicand;
        rem   <= '0;
        root  <= '0;
        cnt   <= 6'd0;
        busy  <= 1'b1;
      end else if (busy) begin
        rad_r <= {rad_r[SumW-3:0], 2'b00};
        rem   <= take ? diff[RemW-1:0] : rem_sh[RemW-1:0];
        root  <= {root[DistW-2:0], take};
        cnt   <= cnt + 6'd1;
        if (cnt == 6'(SumW/2 - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/xpbd_attachment_constraint_step_top.sv
// ----------------------------------------------------------------------------
// xpbd_attachment_constraint_step_top: distance constraint projection
// For one item the divider runs five times, the square root once and the
// multiplier for nine uses, each unit started in turn by the sequencer.
// A new item waits until the last one is through; it enters once the
// sequencer is back in idle, while the last result may still wait for ready.
// Synchronous reset clears the multiplier, the registers and all valids.
// ----------------------------------------------------------------------------
module xpbd_attachment_constraint_step_top
  import xacs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CompW-1:0]   cfg_data,
  xacs_item_if.sink          item,
  xacs_result_if.source      result
);

  // Sequencer state codes. Each arithmetic use is an issue state that
  // starts a unit and a wait state that collects its answer.
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SQ     = 5'd1;
  localparam logic [4:0] ST_SQW    = 5'd2;
  localparam logic [4:0] ST_SQRT   = 5'd3;
  localparam logic [4:0] ST_SQRTW  = 5'd4;
  localparam logic [4:0] ST_TS     = 5'd5;
  localparam logic [4:0] ST_TSW    = 5'd6;
  localparam logic [4:0] ST_ALPHA  = 5'd7;
  localparam logic [4:0] ST_ALPHAW = 5'd8;
  localparam logic [4:0] ST_DEN    = 5'd9;
  localparam logic [4:0] ST_TERM   = 5'd10;
  localparam logic [4:0] ST_TERMW  = 5'd11;
  localparam logic [4:0] ST_NUM    = 5'd12;
  localparam logic [4:0] ST_DEL    = 5'd13;
  localparam logic [4:0] ST_DELW   = 5'd14;
  localparam logic [4:0] ST_SC     = 5'd15;
  localparam logic [4:0] ST_SCW    = 5'd16;
  localparam logic [4:0] ST_MV     = 5'd17;
  localparam logic [4:0] ST_MVW    = 5'd18;
  localparam logic [4:0] ST_MVD    = 5'd19;
  localparam logic [4:0] ST_MVDW   = 5'd20;
  localparam logic [4:0] ST_FIN    = 5'd21;

  // Configuration registers.
  logic [CompW-1:0] compliance;
  logic [31:0]      rest_length;
  logic [31:0]      time_step;

  // Per-item working registers.
  logic [4:0]               state;
  logic [1:0]               k;
  logic signed [PosW-1:0]   pos [3];
  logic signed [PosW:0]     dlt [3];
  logic [PosW-1:0]          dmag [3];
  logic [PosW-1:0]          inv_mass;
  logic [SumW-1:0]          sum;
  logic [DistW-1:0]         distance;
  logic [63:0]              alpha;
  logic [63:0]              den;
  logic signed [63:0]       acc;
  logic signed [63:0]       num;
  logic signed [63:0]       delta;
  logic signed [63:0]       s;
  logic signed [PosW-1:0]   res [3];
  logic [1:0]               status;
  logic                     out_valid;

  // Arithmetic units and their hookup.
  mul_req_t         mul_req;
  div_req_t         div_req;
  logic             mul_done;
  logic [127:0]     mul_prod;
  logic             div_done;
  logic [63:0]      div_quot;
  logic             sqrt_start;
  logic             sqrt_done;
  logic [DistW-1:0] sqrt_root;

  // Combinational helpers for the sequencer steps.
  logic [64:0]        den_sum;
  logic [63:0]        den_c;
  logic signed [63:0] negc;
  logic signed [63:0] term;
  logic [63:0]        num_mag;
  logic signed [63:0] delta_c;
  logic [63:0]        move_mag;
  logic               move_neg;
  logic signed [35:0] move_sum;
  logic signed [31:0] move_res;

  xacs_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  xacs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  xacs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = dlt[i][PosW] ? PosW'(-dlt[i]) : dlt[i][PosW-1:0];
    end
  end

  // Multiplier operand selection by sequencer step.
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = 64'd0;
    mul_req.b     = 64'd0;
    case (state)
      ST_SQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(dmag[k]);
        mul_req.b     = 64'(dmag[k]);
      end
      ST_TS: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(time_step);
        mul_req.b     = 64'(time_step);
      end
      ST_TERM: begin
        mul_req.start = 1'b1;
        mul_req.a     = alpha;
        mul_req.b     = mag64(acc);
      end
      ST_SC: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(inv_mass);
        mul_req.b     = mag64(delta);
      end
      ST_MV: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(dmag[k]);
        mul_req.b     = mag64(s);
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  assign num_mag = mag64(num);

  // Divider operand selection: alpha, the multiplier step, and the moves.
  always_comb begin
    div_req.start = 1'b0;
    div_req.hi    = 64'd0;
    div_req.lo    = 64'd0;
    div_req.den   = 64'd0;
    case (state)
      ST_ALPHA: begin
        div_req.start = 1'b1;
        div_req.hi    = 64'(compliance);
        div_req.den   = mul_prod[63:0];
      end
      ST_DEL: begin
        div_req.start = 1'b1;
        div_req.hi    = {32'd0, num_mag[63:32]};
        div_req.lo    = {num_mag[31:0], 32'd0};
        div_req.den   = den;
      end
      ST_MVD: begin
        div_req.start = 1'b1;
        div_req.hi    = mul_prod[127:64];
        div_req.lo    = mul_prod[63:0];
        div_req.den   = 64'(distance);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (state == ST_SQRT);

  // Denominator is inverse mass in Q32.32 plus alpha, clipped to all ones.
  assign den_sum = {17'd0, inv_mass, 16'd0} + {1'b0, alpha};
  assign den_c   = den_sum[64] ? {64{1'b1}} : den_sum[63:0];

  // Negated violation in Q32.32, and the compliance term on the multiplier.
  assign negc = -((64'(distance) - 64'(rest_length)) <<< 16);
  assign term = signed_from(shift32_sat(mul_prod), acc[63]);

  assign delta_c = signed_from(div_quot, num[63]);

  // Move along one axis: clipped magnitude, sign from the axis and the scale.
  assign move_mag = (div_quot > MOVE_LIMIT) ? MOVE_LIMIT : div_quot;
  assign move_neg = dlt[k][PosW] != s[63];
  assign move_sum = 36'(pos[k]) + (move_neg ? -$signed(36'(move_mag))
                                            : $signed(36'(move_mag)));
  always_comb begin
    if (move_sum > 36'sd2147483647) begin
      move_res = 32'sh7fff_ffff;
    end else if (move_sum < -36'sd2147483648) begin
      move_res = 32'sh8000_0000;
    end else begin
      move_res = move_sum[31:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      compliance  <= '0;
      rest_length <= 32'd0;
      time_step   <= TIME_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMPLIANCE:  compliance  <= cfg_data;
        REG_REST_LENGTH: rest_length <= cfg_data[31:0];
        REG_TIME_STEP:   time_step   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  assign item.ready   = (state == ST_IDLE);
  assign result.valid = out_valid;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= 2'd0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finish step reloads the output register itself, so the plain
      // drain only applies outside it.
      if (result.valid && result.ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            pos[0]   <= item.pos_x;
            pos[1]   <= item.pos_y;
            pos[2]   <= item.pos_z;
            res[0]   <= item.pos_x;
            res[1]   <= item.pos_y;
            res[2]   <= item.pos_z;
            dlt[0]   <= 33'(item.pos_x) - 33'(item.anchor_x);
            dlt[1]   <= 33'(item.pos_y) - 33'(item.anchor_y);
            dlt[2]   <= 33'(item.pos_z) - 33'(item.anchor_z);
            inv_mass <= item.inv_mass;
            sum      <= '0;
            status   <= STATUS_UPDATED;
            k        <= 2'd0;
            if (item.clear_multiplier) begin
              acc <= '0;
            end
            state <= ST_SQ;
          end
        end
        ST_SQ:   state <= ST_SQW;
        ST_SQW: begin
          if (mul_done) begin
            sum <= sum + SumW'(mul_prod[63:0]);
            k   <= k + 2'd1;
            state <= (k == 2'd2) ? ST_SQRT : ST_SQ;
          end
        end
        ST_SQRT: state <= ST_SQRTW;
        ST_SQRTW: begin
          if (sqrt_done) begin
            distance <= sqrt_root;
            state    <= ST_TS;
          end
        end
        ST_TS:  state <= ST_TSW;
        ST_TSW: begin
          if (mul_done) begin
            state <= ST_ALPHA;
          end
        end
        ST_ALPHA: state <= ST_ALPHAW;
        ST_ALPHAW: begin
          if (div_done) begin
            alpha <= div_quot;
            state <= ST_DEN;
          end
        end
        ST_DEN: begin
          den <= den_c;
          // A zero distance or zero denominator leaves the position as is.
          if (distance == '0) begin
            status <= STATUS_NEAR_DIST;
            state  <= ST_FIN;
          end else if (den_c == 64'd0) begin
            status <= STATUS_NEAR_DEN;
            state  <= ST_FIN;
          end else begin
            state <= ST_TERM;
          end
        end
        ST_TERM:  state <= ST_TERMW;
        ST_TERMW: begin
          if (mul_done) begin
            state <= ST_NUM;
          end
        end
        ST_NUM: begin
          num   <= sat_add64(negc, -term);
          state <= ST_DEL;
        end
        ST_DEL:  state <= ST_DELW;
        ST_DELW: begin
          if (div_done) begin
            delta <= delta_c;
            acc   <= sat_add64(acc, delta_c);
            state <= ST_SC;
          end
        end
        ST_SC:  state <= ST_SCW;
        ST_SCW: begin
          if (mul_done) begin
            s     <= signed_from(shift32_sat(mul_prod), delta[63]);
            k     <= 2'd0;
            state <= ST_MV;
          end
        end
        ST_MV:  state <= ST_MVW;
        ST_MVW: begin
          if (mul_done) begin
            state <= ST_MVD;
          end
        end
        ST_MVD: state <= ST_MVDW;
        ST_MVDW: begin
          if (div_done) begin
            res[k] <= move_res;
            k      <= k + 2'd1;
            state  <= (k == 2'd2) ? ST_FIN : ST_MV;
          end
        end
        ST_FIN: begin
          // Hand the beat to the output register once it is free.
          if (!out_valid || result.ready) begin
            result.new_x      <= res[0];
            result.new_y      <= res[1];
            result.new_z      <= res[2];
            result.multiplier <= acc;
            result.status     <= status;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/xacs_check.sv
// ----------------------------------------------------------------------------
// xacs_check: port-level checks for the attachment constraint step
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module xacs_check
  import xacs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_x,
  input logic [63:0] out_multiplier,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_new_x) &&
                                $stable(out_multiplier))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while the previous one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == STATUS_UPDATED || out_status == STATUS_NEAR_DIST ||
                   out_status == STATUS_NEAR_DEN))
    else $error("result status out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind xpbd_attachment_constraint_step_top xacs_check u_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_new_x      (result.new_x),
  .out_multiplier (result.multiplier),
  .out_status     (result.status)
);

>>> tb/xpbd_attachment_constraint_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpbd_attachment_constraint_step_top_tb: self-checking bench for the step
// Drives particle/anchor beats through the item channel and checks every
// result beat against a fixed-point projection computed in the bench. The
// run steps through several register settings, including the extremes, with
// random idle gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module xpbd_attachment_constraint_step_top_tb;
  import xacs_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic        [31:0] inv_mass;
    logic signed [31:0] ax, ay, az;
    logic               clear;
  } particle_t;

  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic signed [63:0] mult;
    logic        [1:0]  status;
  } projection_t;

  // Scoreboard: holds its own copy of the registers and the multiplier, and
  // a queue of projected results in acceptance order.
  class projection_board;
    logic [47:0] compliance;
    logic [31:0] rest_length;
    logic [31:0] time_step;
    logic signed [63:0] lambda;
    projection_t pending_q[$];
    int errors;

    function void clear_state();
      compliance  = '0;
      rest_length = '0;
      time_step   = TIME_STEP_RESET;
      lambda      = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [47:0] val);
      case (idx)
        REG_COMPLIANCE:  compliance  = val;
        REG_REST_LENGTH: rest_length = val[31:0];
        REG_TIME_STEP:   time_step   = val[31:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] abs64(logic signed [63:0] x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // Clip a magnitude to the positive limit and apply the sign.
    function logic signed [63:0] apply_sign(logic [63:0] m, logic neg);
      logic signed [63:0] v;
      v = m[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m);
      return neg ? -v : v;
    endfunction

    function logic signed [63:0] clip_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
    endfunction

    // Wide quotient; all ones when the divisor is zero or the quotient overflows.
    function logic [63:0] quot(logic [63:0] hi, logic [63:0] lo, logic [63:0] d);
      logic [127:0] q;
      if (d == 0 || hi >= d) return '1;
      q = {hi, lo} / {64'd0, d};
      return q[63:0];
    endfunction

    function logic [63:0] prod_q32(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return (p[127:96] != 0) ? '1 : p[95:32];
    endfunction

    function projection_t project(particle_t it);
      projection_t r;
      logic signed [63:0] pos[3], dd[3], negc, term, num, delta, s, v;
      logic [127:0] sumsq, p, t2;
      logic [63:0] distance, t, alpha, den, m;
      logic [64:0] den_w;
      pos[0] = it.px; pos[1] = it.py; pos[2] = it.pz;
      dd[0] = pos[0] - 64'(it.ax);
      dd[1] = pos[1] - 64'(it.ay);
      dd[2] = pos[2] - 64'(it.az);
      sumsq = '0;
      for (int i = 0; i < 3; i++) sumsq += 128'(abs64(dd[i])) * 128'(abs64(dd[i]));
      if (it.clear) lambda = '0;
      distance = '0;
      for (int b = 34; b >= 0; b--) begin
        t = distance | (64'd1 << b);
        t2 = 128'(t) * 128'(t);
        if (t2 <= sumsq) distance = t;
      end
      alpha = quot({16'd0, compliance}, '0, 64'(time_step) * 64'(time_step));
      den_w = 65'({it.inv_mass, 16'd0}) + 65'(alpha);
      den = den_w[64] ? '1 : den_w[63:0];
      r.nx = it.px; r.ny = it.py; r.nz = it.pz;
      r.status = STATUS_UPDATED;
      if (distance == 0) begin
        r.status = STATUS_NEAR_DIST;
      end else if (den == 0) begin
        r.status = STATUS_NEAR_DEN;
      end else begin
        negc = -(($signed(distance) - $signed(64'(rest_length))) * 64'sd65536);
        term = apply_sign(prod_q32(alpha, abs64(lambda)), lambda < 0);
        num = clip_add(negc, -term);
        m = abs64(num);
        delta = apply_sign(quot(m >> 32, m << 32, den), num < 0);
        lambda = clip_add(lambda, delta);
        s = apply_sign(prod_q32(64'(it.inv_mass), abs64(delta)), delta < 0);
        for (int i = 0; i < 3; i++) begin
          p = 128'(abs64(dd[i])) * 128'(abs64(s));
          m = quot(p[127:64], p[63:0], distance);
          if (m > MOVE_LIMIT) m = MOVE_LIMIT;
          v = pos[i] + apply_sign(m, (dd[i] < 0) != (s < 0));
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          pos[i] = v;
        end
        r.nx = pos[0][31:0]; r.ny = pos[1][31:0]; r.nz = pos[2][31:0];
      end
      r.mult = lambda;
      return r;
    endfunction

    function void note_item(particle_t it);
      pending_q.push_back(project(it));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(projection_t got);
      projection_t want;
      if (pending_q.size() == 0) begin
        report("unexpected beat", 64'(got.status), '0);
        return;
      end
      want = pending_q.pop_front();
      if (got.nx !== want.nx) report("new_x", 64'(got.nx), 64'(want.nx));
      if (got.ny !== want.ny) report("new_y", 64'(got.ny), 64'(want.ny));
      if (got.nz !== want.nz) report("new_z", 64'(got.nz), 64'(want.nz));
      if (got.mult !== want.mult) report("multiplier", got.mult, want.mult);
      if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;

  xacs_item_if   item_ch();
  xacs_result_if result_ch();

  xpbd_attachment_constraint_step_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch.sink),
    .result    (result_ch.source)
  );

  projection_board board;

  // Set by the sender to ask the result side for a long stall; the receiver
  // counts the stall down in its own process.
  int  long_hold_req;
  // When set, a side runs without idle gaps for a while.
  bit  item_burst;
  bit  result_burst;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous fixed limit: the slowest correct run is well under 10 ms.
  initial begin
    #60ms;
    $display("xpbd_attachment_constraint_step_top_tb failed");
    $finish;
  end

  // Result side. Ready is driven at the falling edge, beats are taken at
  // the rising edge.
  initial begin
    int gap;
    int beats;
    gap = 0;
    beats = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        result_ch.ready = 1'b0;
        long_hold_req--;
      end else if (gap > 0) begin
        result_ch.ready = 1'b0;
        gap--;
      end else begin
        result_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        projection_t got;
        got.nx = result_ch.new_x;
        got.ny = result_ch.new_y;
        got.nz = result_ch.new_z;
        got.mult = result_ch.multiplier;
        got.status = result_ch.status;
        board.check_result(got);
        beats++;
        if (beats % 150 == 0) result_burst = !result_burst;
        gap = result_burst ? 0 : $urandom_range(0, 18);
      end
    end
  end

  // Offer one beat after a random gap; valid stays high across back-to-back
  // beats because only blocking assignments at the falling edge touch it.
  task automatic send_item(particle_t it);
    int gap;
    gap = item_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.pos_x = it.px;
    item_ch.pos_y = it.py;
    item_ch.pos_z = it.pz;
    item_ch.inv_mass = it.inv_mass;
    item_ch.anchor_x = it.ax;
    item_ch.anchor_y = it.ay;
    item_ch.anchor_z = it.az;
    item_ch.clear_multiplier = it.clear;
    item_ch.valid = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    board.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers change only when the block is idle: all results back and a
  // short settle time on top.
  task automatic wait_idle();
    item_ch.valid = 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
    logic signed [63:0] v;
    v = 64'(base) + $signed(64'($urandom_range(0, 2 * span))) - span;
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = 64'(base);
    return v[31:0];
  endfunction

  // Mostly particles within a sensible distance of the anchor, plus some
  // fully random beats, coincident points and pinned particles.
  function automatic particle_t random_particle();
    particle_t it;
    int kind;
    int span;
    kind = $urandom_range(0, 9);
    span = 1 << $urandom_range(4, 22);
    it.ax = $urandom_range(0, 1) ? $signed($urandom()) : near(0, 1 << 22);
    it.ay = $urandom_range(0, 1) ? $signed($urandom()) : near(0, 1 << 22);
    it.az = $urandom_range(0, 1) ? $signed($urandom()) : near(0, 1 << 22);
    it.px = near(it.ax, span);
    it.py = near(it.ay, span);
    it.pz = near(it.az, span);
    case ($urandom_range(0, 5))
      0: it.inv_mass = $urandom();
      1: it.inv_mass = '0;
      default: it.inv_mass = $urandom_range(0, 1 << 18);
    endcase
    if (kind == 0) begin
      it.px = $urandom(); it.py = $urandom(); it.pz = $urandom();
      it.ax = $urandom(); it.ay = $urandom(); it.az = $urandom();
    end else if (kind == 1) begin
      it.px = it.ax; it.py = it.ay; it.pz = it.az;
    end
    it.clear = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  function automatic particle_t mk(logic signed [31:0] px, logic signed [31:0] py,
                                   logic signed [31:0] pz, logic [31:0] im,
                                   logic signed [31:0] ax, logic signed [31:0] ay,
                                   logic signed [31:0] az, logic cl);
    particle_t it;
    it.px = px; it.py = py; it.pz = pz; it.inv_mass = im;
    it.ax = ax; it.ay = ay; it.az = az; it.clear = cl;
    return it;
  endfunction

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  initial begin
    board = new();
    board.clear_state();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_COMPLIANCE;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.pos_x = '0; item_ch.pos_y = '0; item_ch.pos_z = '0;
    item_ch.inv_mass = '0;
    item_ch.anchor_x = '0; item_ch.anchor_y = '0; item_ch.anchor_z = '0;
    item_ch.clear_multiplier = 1'b0;
    long_hold_req = 0;
    item_burst = 1'b0;
    result_burst = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed beats under the reset register values.
    send_item(mk(ONE, 0, 0, ONE, 0, 0, 0, 1'b0));
    // Coincident points: distance too small, with a clear riding along.
    send_item(mk(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1));
    // Pinned particle with zero compliance: denominator too small.
    send_item(mk(ONE, 2 * ONE, 0, 0, 0, 0, 0, 1'b0));
    send_item(mk(PMAX, PMAX, PMAX, 32'hFFFF_FFFF, PMIN, PMIN, PMIN, 1'b0));
    send_item(mk(PMIN, PMIN, PMIN, 32'hFFFF_FFFF, PMAX, PMAX, PMAX, 1'b0));
    send_item(mk(PMAX, 0, PMIN, ONE, 0, 0, 0, 1'b1));
    send_item(mk(1, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1'b0));
    send_item(mk(-1, -1, -1, 1, 0, 0, 0, 1'b0));
    send_item(mk(0, 0, 0, ONE, PMAX, PMAX, PMAX, 1'b0));
    send_item(mk(0, 3 * ONE, -4 * ONE, 2 * ONE, 0, 0, 0, 1'b0));
    wait_idle();

    // Maximum compliance and rest length with the shortest time step: the
    // scaled compliance saturates and the multiplier term dominates.
    write_reg(REG_COMPLIANCE, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_REST_LENGTH, 48'h0000_FFFF_FFFF);
    write_reg(REG_TIME_STEP, 48'd1);
    send_item(mk(ONE, 0, 0, 0, 0, 0, 0, 1'b1));
    send_item(mk(PMAX, PMAX, PMAX, 32'hFFFF_FFFF, PMIN, PMIN, PMIN, 1'b0));
    send_item(mk(2 * ONE, 0, 0, ONE, 0, 0, 0, 1'b0));
    send_item(mk(5, 5, 5, ONE, 5, 5, 5, 1'b1));
    wait_idle();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_COMPLIANCE, '0);
          write_reg(REG_REST_LENGTH, 48'(ONE));
          write_reg(REG_TIME_STEP, 48'(TIME_STEP_RESET));
        end
        1: begin
          write_reg(REG_COMPLIANCE, 48'd1 << 26);
          write_reg(REG_REST_LENGTH, 48'h0000_0000_8000);
          write_reg(REG_TIME_STEP, 48'h0000_FFFF_FFFF);
        end
        2: begin
          write_reg(REG_COMPLIANCE, 48'hFFFF_FFFF_FFFF);
          write_reg(REG_REST_LENGTH, 48'h0000_FFFF_FFFF);
          write_reg(REG_TIME_STEP, 48'd1);
        end
        3: begin
          write_reg(REG_COMPLIANCE, 48'd0);
          write_reg(REG_REST_LENGTH, 48'd0);
          write_reg(REG_TIME_STEP, 48'h0000_FFFF_FFFF);
        end
        default: begin
          write_reg(REG_COMPLIANCE,
                    48'({$urandom(), $urandom()} >> $urandom_range(16, 40)));
          write_reg(REG_REST_LENGTH, 48'($urandom() >> $urandom_range(0, 16)));
          write_reg(REG_TIME_STEP, 48'($urandom_range(1, 32'hFFFF_FFFF)));
        end
      endcase
      for (int n = 0; n < 280; n++) begin
        if (n % 70 == 0) item_burst = !item_burst;
        // Stall results for a long stretch so that the block backs up and
        // drops item ready while beats keep being offered.
        if (ph == 0 && n == 40) long_hold_req = 3000;
        send_item(random_particle());
      end
      wait_idle();
    end

    item_ch.valid = 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (board.errors == 0) begin
      $display("xpbd_attachment_constraint_step_top_tb passed");
    end else begin
      $display("xpbd_attachment_constraint_step_top_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/xacs_pkg.sv
src/xacs_if.sv
src/xacs_mul.sv
src/xacs_div.sv
src/xacs_sqrt.sv
src/xpbd_attachment_constraint_step_top.sv
src/xacs_check.sv
tb/xpbd_attachment_constraint_step_top_tb.sv
